/* rtl/md5_pkg.sv */
// md5 package: constants, state enum and round tables
package md5_pkg;

  localparam int unsigned CountW = 61;

  localparam logic [31:0] Iv0 = 32'h67452301;
  localparam logic [31:0] Iv1 = 32'hEFCDAB89;
  localparam logic [31:0] Iv2 = 32'h98BADCFE;
  localparam logic [31:0] Iv3 = 32'h10325476;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

  localparam logic KindData   = 1'b0;
  localparam logic KindFinish = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StPad,
    StRound,
    StFold,
    StEmit
  } state_e;

  function automatic logic [31:0] add_const(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hD76AA478; 6'd1:  k = 32'hE8C7B756;
      6'd2:  k = 32'h242070DB; 6'd3:  k = 32'hC1BDCEEE;
      6'd4:  k = 32'hF57C0FAF; 6'd5:  k = 32'h4787C62A;
      6'd6:  k = 32'hA8304613; 6'd7:  k = 32'hFD469501;
      6'd8:  k = 32'h698098D8; 6'd9:  k = 32'h8B44F7AF;
      6'd10: k = 32'hFFFF5BB1; 6'd11: k = 32'h895CD7BE;
      6'd12: k = 32'h6B901122; 6'd13: k = 32'hFD987193;
      6'd14: k = 32'hA679438E; 6'd15: k = 32'h49B40821;
      6'd16: k = 32'hF61E2562; 6'd17: k = 32'hC040B340;
      6'd18: k = 32'h265E5A51; 6'd19: k = 32'hE9B6C7AA;
      6'd20: k = 32'hD62F105D; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hD8A1E681; 6'd23: k = 32'hE7D3FBC8;
      6'd24: k = 32'h21E1CDE6; 6'd25: k = 32'hC33707D6;
      6'd26: k = 32'hF4D50D87; 6'd27: k = 32'h455A14ED;
      6'd28: k = 32'hA9E3E905; 6'd29: k = 32'hFCEFA3F8;
      6'd30: k = 32'h676F02D9; 6'd31: k = 32'h8D2A4C8A;
      6'd32: k = 32'hFFFA3942; 6'd33: k = 32'h8771F681;
      6'd34: k = 32'h6D9D6122; 6'd35: k = 32'hFDE5380C;
      6'd36: k = 32'hA4BEEA44; 6'd37: k = 32'h4BDECFA9;
      6'd38: k = 32'hF6BB4B60; 6'd39: k = 32'hBEBFBC70;
      6'd40: k = 32'h289B7EC6; 6'd41: k = 32'hEAA127FA;
      6'd42: k = 32'hD4EF3085; 6'd43: k = 32'h04881D05;
      6'd44: k = 32'hD9D4D039; 6'd45: k = 32'hE6DB99E5;
      6'd46: k = 32'h1FA27CF8; 6'd47: k = 32'hC4AC5665;
      6'd48: k = 32'hF4292244; 6'd49: k = 32'h432AFF97;
      6'd50: k = 32'hAB9423A7; 6'd51: k = 32'hFC93A039;
      6'd52: k = 32'h655B59C3; 6'd53: k = 32'h8F0CCC92;
      6'd54: k = 32'hFFEFF47D; 6'd55: k = 32'h85845DD1;
      6'd56: k = 32'h6FA87E4F; 6'd57: k = 32'hFE2CE6E0;
      6'd58: k = 32'hA3014314; 6'd59: k = 32'h4E0811A1;
      6'd60: k = 32'hF7537E82; 6'd61: k = 32'hBD3AF235;
      6'd62: k = 32'h2AD7D2BB; 6'd63: k = 32'hEB86D391;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] i);
    logic [4:0] r;
    case ({i[5:4], i[1:0]})
      4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
      4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
      4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; 4'd15: r = 5'd21;
      default: r = '0;
    endcase
    return r;
  endfunction

  // message word index used in round i
  function automatic logic [3:0] word_sel(input logic [5:0] i);
    logic [3:0] g;
    logic [3:0] n;
    n = i[3:0];
    case (i[5:4])
      2'd0: g = n;
      2'd1: g = 4'((n << 2) + n + 4'd1);
      2'd2: g = 4'((n << 1) + n + 4'd5);
      2'd3: g = 4'((n << 3) - n);
      default: g = n;
    endcase
    return g;
  endfunction

endpackage

/* rtl/md5_if.sv */
// valid/ready channel interfaces for the md5 engine
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  modport source (output valid, kind, data_byte, input ready);
  modport sink (input valid, kind, data_byte, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* rtl/md5_hash_engine.sv */
// md5 hash engine top level: byte buffer, padding sequencer and digest output
// a data byte is written to the buffer; a byte that completes a block also runs
//   the 64 rounds of the shared round unit and the fold into the chaining value
// a finish writes the pad bytes and the length, and compresses each padded block,
//   then the four digest words go out, one per cycle while the sink is ready
// throughput: one item at a time; ready is low while padding, rounds or output run
// reset: asynchronous active low, loads the initial chaining value and clears the count
module md5_hash_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  md5_in_if.sink      in_i,
  md5_out_if.source   out_o
);

  md5_pkg::state_e state_q, state_d;

  // block buffer, one 32-bit word per four bytes
  logic [31:0] buf_mem [16];

  logic [md5_pkg::CountW-1:0] cnt_q, cnt_d;   // message byte count
  logic [5:0]  pos_q, pos_d;                  // buffer write position while padding
  logic [3:0]  pad_n_q, pad_n_d;              // pad step within the length field
  logic        pad_len_q, pad_len_d;          // writing length bytes
  logic        first_q, first_d;              // next pad byte is the 0x80 marker
  logic        fin_q, fin_d;                  // compression belongs to a finish
  logic [1:0]  widx_q, widx_d;

  logic        wr_en;
  logic [5:0]  wr_pos;
  logic [7:0]  wr_byte;
  logic [63:0] bit_len;

  logic        core_start;
  logic        core_busy, core_done, core_init;
  logic [3:0]  core_widx;
  logic [3:0][31:0] cv;

  assign bit_len = {cnt_q, 3'b000};

  md5_round u_round (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (core_start),
    .busy_o     (core_busy),
    .done_o     (core_done),
    .word_idx_o (core_widx),
    .word_i     (buf_mem[core_widx]),
    .cv_o       (cv),
    .init_i     (core_init)
  );

  // byte lanes of the buffer words
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      buf_mem[wr_pos[5:2]][8*wr_pos[1:0] +: 8] <= wr_byte;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    pad_n_d   = pad_n_q;
    pad_len_d = pad_len_q;
    first_d   = first_q;
    fin_d     = fin_q;
    widx_d    = widx_q;
    wr_en     = 1'b0;
    wr_pos    = pos_q;
    wr_byte   = '0;
    core_start = 1'b0;
    core_init = 1'b0;
    in_i.ready  = 1'b0;
    out_o.valid = 1'b0;

    case (state_q)
      md5_pkg::StIdle: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          if (in_i.kind == md5_pkg::KindData) begin
            wr_en   = 1'b1;
            wr_pos  = cnt_q[5:0];
            wr_byte = in_i.data_byte;
            cnt_d   = cnt_q + 1'b1;
            if (cnt_q[5:0] == 6'd63) begin
              fin_d   = 1'b0;
              state_d = md5_pkg::StRound;
            end
          end else begin
            pos_d     = cnt_q[5:0];
            first_d   = 1'b1;
            pad_len_d = 1'b0;
            pad_n_d   = '0;
            fin_d     = 1'b1;
            state_d   = md5_pkg::StPad;
          end
        end
      end
      md5_pkg::StPad: begin
        wr_en = 1'b1;
        if (pad_len_q) begin
          wr_byte = bit_len[8*pad_n_q[2:0] +: 8];
          pad_n_d = pad_n_q + 4'd1;
        end else if (first_q) begin
          wr_byte = md5_pkg::PadByte;
          first_d = 1'b0;
        end
        pos_d = pos_q + 6'd1;
        if (!pad_len_q && pos_q == md5_pkg::LenPos - 6'd1) begin
          pad_len_d = 1'b1;
        end
        if (pos_q == 6'd63) begin
          state_d = md5_pkg::StRound;
        end
      end
      md5_pkg::StRound: begin
        // start pulse on entry, then wait for the fold
        if (!core_busy) begin
          core_start = 1'b1;
          state_d    = md5_pkg::StFold;
        end
      end
      md5_pkg::StFold: begin
        if (core_done) begin
          if (!fin_q) begin
            state_d = md5_pkg::StIdle;
          end else if (pad_len_q && pad_n_q == 4'd8) begin
            widx_d  = '0;
            state_d = md5_pkg::StEmit;
          end else begin
            state_d = md5_pkg::StPad;
          end
        end
      end
      md5_pkg::StEmit: begin
        out_o.valid = 1'b1;
        if (out_o.ready) begin
          widx_d = widx_q + 2'd1;
          if (widx_q == 2'd3) begin
            core_init = 1'b1;
            cnt_d     = '0;
            state_d   = md5_pkg::StIdle;
          end
        end
      end
      default: state_d = md5_pkg::StIdle;
    endcase
  end

  assign out_o.digest_word = cv[widx_q];
  assign out_o.word_index  = widx_q;
  assign out_o.last_word   = (widx_q == 2'd3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= md5_pkg::StIdle;
      cnt_q     <= '0;
      pos_q     <= '0;
      pad_n_q   <= '0;
      pad_len_q <= 1'b0;
      first_q   <= 1'b0;
      fin_q     <= 1'b0;
      widx_q    <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      pos_q     <= pos_d;
      pad_n_q   <= pad_n_d;
      pad_len_q <= pad_len_d;
      first_q   <= first_d;
      fin_q     <= fin_d;
      widx_q    <= widx_d;
    end
  end

endmodule

/* rtl/md5_round.sv */
// md5 round engine: one shared round datapath, 64 rounds plus fold
module md5_round (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic [3:0]              word_idx_o,
  input  logic [31:0]             word_i,
  output logic [3:0][31:0]        cv_o,
  input  logic                    init_i
);

  logic [3:0][31:0] cv_q, cv_d;
  logic [31:0] a_q, b_q, c_q, d_q, a_d, b_d, c_d, d_d;
  logic [5:0]  rnd_q, rnd_d;
  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [31:0] f, t;
  logic [4:0]  r;
  logic [63:0] dbl;

  assign word_idx_o = md5_pkg::word_sel(rnd_q);
  assign r = md5_pkg::rot_amount(rnd_q);

  always_comb begin
    case (rnd_q[5:4])
      2'd0: f = d_q ^ (b_q & (c_q ^ d_q));
      2'd1: f = c_q ^ (d_q & (b_q ^ c_q));
      2'd2: f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
    t = a_q + f + word_i + md5_pkg::add_const(rnd_q);
    dbl = {t, t} << r;
  end

  always_comb begin
    cv_d = cv_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q;
    rnd_d = rnd_q;
    run_d = run_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d = cv_q[0]; b_d = cv_q[1]; c_d = cv_q[2]; d_d = cv_q[3];
      rnd_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      a_d = d_q;
      d_d = c_q;
      c_d = b_q;
      b_d = b_q + dbl[63:32];
      rnd_d = rnd_q + 6'd1;
      if (rnd_q == 6'd63) begin
        run_d = 1'b0;
        done_d = 1'b1;
        // fold working words back into the chaining value
        cv_d[0] = cv_q[0] + d_q;
        cv_d[1] = cv_q[1] + b_d;
        cv_d[2] = cv_q[2] + b_q;
        cv_d[3] = cv_q[3] + c_q;
      end
    end
    if (init_i) begin
      cv_d = {md5_pkg::Iv3, md5_pkg::Iv2, md5_pkg::Iv1, md5_pkg::Iv0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q   <= {md5_pkg::Iv3, md5_pkg::Iv2, md5_pkg::Iv1, md5_pkg::Iv0};
      rnd_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cv_q   <= cv_d;
      rnd_q  <= rnd_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d;
  end

  assign busy_o = run_q;
  assign done_o = done_q;
  assign cv_o   = cv_q;

endmodule
